// File: rtl/core/msrh_pkg.sv
// msrh_pkg: shared types and constants for the Modbus slave request handler.
// Request/response word layouts, function and exception codes, and the
// command/status structs that join the controller and the datapath.
package msrh_pkg;

    localparam int REG_COUNT  = 8;
    localparam int COIL_COUNT = 8;
    localparam int REG_AW     = $clog2(REG_COUNT);

    // Item actions
    localparam logic [1:0] ACT_HEADER  = 2'd0;
    localparam logic [1:0] ACT_PAYLOAD = 2'd1;
    localparam logic [1:0] ACT_LOAD    = 2'd2;

    // Function codes
    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT    = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
    localparam logic [7:0] FC_WRITE_REG     = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

    // Response kinds
    localparam logic [2:0] KIND_EXC  = 3'd0;
    localparam logic [2:0] KIND_BITS = 3'd1;
    localparam logic [2:0] KIND_HDR  = 3'd2;
    localparam logic [2:0] KIND_WORD = 3'd3;
    localparam logic [2:0] KIND_ECHO = 3'd4;

    // Exception codes
    localparam logic [1:0] EXC_ILLEGAL_FUNC  = 2'd0;
    localparam logic [1:0] EXC_ILLEGAL_ADDR  = 2'd1;
    localparam logic [1:0] EXC_ILLEGAL_VALUE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_OWN_ADDRESS     = 1'b0;
    localparam logic CFG_DISCRETE_INPUTS = 1'b1;

    localparam logic [7:0] OWN_ADDRESS_RST = 8'h01;
    localparam logic [7:0] DISCRETE_RST    = 8'b0000_1001;
    localparam logic [7:0] COIL_RST        = 8'b0000_0101;
    localparam logic [7:0] COIL_ON         = 8'hFF;
    localparam logic [7:0] COIL_OFF        = 8'h00;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [7:0]  start_hi;
        logic [7:0]  start_lo;
        logic [7:0]  qty_hi;
        logic [7:0]  qty_lo;
        logic [7:0]  coil_values;
        logic [15:0] word;
        logic [2:0]  load_index;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  func_echo;
        logic [1:0]  exception_code;
        logic [15:0] echo_address;
        logic [15:0] echo_value;
        logic [7:0]  bit_data;
        logic [15:0] reg_word;
        logic [4:0]  byte_count;
        logic        last;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic latch;      // capture the incoming item
        logic commit;     // apply the item, load its first result if any
        logic emit_word;  // load the next register word of a read
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic has_rsp;    // the latched item yields a result now
        logic multi;      // register words follow the header
        logic out_free;   // output register can take a word this cycle
        logic word_last;  // next word emitted is the final one
    } t_dp_status;

endpackage

// File: rtl/core/msrh_ctrl.sv
// msrh_ctrl: sequencing state machine of the request handler.
// Depends on msrh_pkg for the command and status structs.
module msrh_ctrl
    import msrh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WORDS
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // wait for room only when there is something to show
                if (!i_status.has_rsp || i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = i_status.multi ? ST_WORDS : ST_IDLE;
                end
            end
            ST_WORDS: begin
                if (i_status.out_free) begin
                    o_cmd.emit_word = 1'b1;
                    if (i_status.word_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != ST_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

// File: rtl/core/msrh_dp.sv
// msrh_dp: datapath of the request handler: config, coils, register stores,
// request decode and the output register. Depends on msrh_pkg.
module msrh_dp
    import msrh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output t_rsp       o_out_data
);

    logic [7:0]  r_own_address;
    logic [7:0]  r_discrete;
    logic [7:0]  r_coils;
    logic [15:0] r_holding [REG_COUNT];
    logic [15:0] r_input   [REG_COUNT];

    logic [3:0]        r_pay_left;
    logic [REG_AW-1:0] r_pay_index;
    logic [15:0]       r_pend_addr;
    logic [15:0]       r_pend_value;
    logic              r_discard;

    t_req              r_req;
    logic [3:0]        r_word_left;
    logic [REG_AW-1:0] r_word_ptr;
    logic              r_word_input;
    logic              r_out_valid;
    t_rsp              r_out;

    // decode of the latched item
    t_rsp              n_rsp;
    t_rsp              word_rsp;
    logic              has_rsp;
    logic              multi;
    logic              addressed;
    logic              bad_coil;
    logic              bad_reg;
    logic [8:0]        span_end;
    logic [7:0]        mask;
    logic [7:0]        bit_src;
    logic [7:0]        n_coils;
    logic              coils_we;
    logic              hold_we;
    logic [REG_AW-1:0] hold_addr;
    logic [15:0]       hold_data;
    logic              hdr_clear;
    logic              set_discard;
    logic              start_pay;
    logic              pay_step;
    logic [2:0]        k;
    logic [2:0]        t;
    logic [REG_AW-1:0] sl_idx;
    logic              out_free;

    assign sl_idx    = r_req.start_lo[REG_AW-1:0];
    assign span_end  = {1'b0, r_req.start_lo} + {1'b0, r_req.qty_lo};
    assign addressed = (r_req.slave_address == r_own_address) || (r_req.slave_address == 8'd0);
    assign bad_coil  = (r_req.start_hi != 8'd0) || (r_req.qty_hi != 8'd0)
                    || (r_req.start_lo >= 8'(COIL_COUNT)) || (span_end > 9'(COIL_COUNT));
    assign bad_reg   = (r_req.start_hi != 8'd0) || (r_req.qty_hi != 8'd0)
                    || (r_req.start_lo >= 8'(REG_COUNT)) || (span_end > 9'(REG_COUNT));
    assign bit_src   = (r_req.function_code == FC_READ_COILS) ? r_coils : r_discrete;
    assign mask      = (r_req.qty_lo == 8'd0) ? 8'd0 : (8'hFF >> (4'd8 - r_req.qty_lo[3:0]));
    assign out_free  = !r_out_valid || !i_out_stall;

    // coils written by a multiple-coil request (bit-reversed mapping kept)
    always_comb begin
        n_coils = r_coils;
        for (int p = 0; p < COIL_COUNT; p++) begin
            t = 3'(7 - p);
            k = t - r_req.start_lo[2:0];
            if ((t >= r_req.start_lo[2:0]) && ({1'b0, k} < r_req.qty_lo[3:0])) begin
                n_coils[p] = r_req.coil_values[3'd7 - k];
            end
        end
    end

    always_comb begin
        n_rsp       = '0;
        has_rsp     = 1'b0;
        multi       = 1'b0;
        coils_we    = 1'b0;
        hold_we     = 1'b0;
        hold_addr   = sl_idx;
        hold_data   = {r_req.qty_hi, r_req.qty_lo};
        hdr_clear   = 1'b0;
        set_discard = 1'b0;
        start_pay   = 1'b0;
        pay_step    = 1'b0;
        n_rsp.func_echo = r_req.function_code;
        n_rsp.last      = 1'b1;
        case (r_req.action)
            ACT_HEADER: begin
                hdr_clear = 1'b1;
                if (!addressed) begin
                    set_discard = (r_req.function_code == FC_WRITE_REGS);
                end else begin
                    has_rsp    = 1'b1;
                    n_rsp.kind = KIND_EXC;
                    case (r_req.function_code)
                        FC_READ_COILS, FC_READ_DISCRETE: begin
                            if (bad_coil) begin
                                n_rsp.exception_code = EXC_ILLEGAL_ADDR;
                            end else begin
                                n_rsp.kind       = KIND_BITS;
                                n_rsp.bit_data   = (bit_src >> r_req.start_lo[2:0]) & mask;
                                n_rsp.byte_count = 5'd1;
                            end
                        end
                        FC_READ_HOLDING, FC_READ_INPUT: begin
                            if (bad_reg) begin
                                n_rsp.exception_code = EXC_ILLEGAL_ADDR;
                            end else begin
                                n_rsp.kind       = KIND_HDR;
                                n_rsp.byte_count = {r_req.qty_lo[3:0], 1'b0};
                                n_rsp.last       = (r_req.qty_lo == 8'd0);
                                multi            = (r_req.qty_lo != 8'd0);
                            end
                        end
                        FC_WRITE_COIL: begin
                            if ((r_req.start_hi != 8'd0) || (r_req.qty_lo != 8'd0)
                                || (r_req.start_lo >= 8'(COIL_COUNT))) begin
                                n_rsp.exception_code = EXC_ILLEGAL_ADDR;
                            end else if ((r_req.qty_hi != COIL_ON) && (r_req.qty_hi != COIL_OFF)) begin
                                n_rsp.exception_code = EXC_ILLEGAL_VALUE;
                            end else begin
                                n_rsp.kind         = KIND_ECHO;
                                n_rsp.echo_address = {8'd0, r_req.start_lo};
                                n_rsp.echo_value   = {r_req.qty_hi, 8'd0};
                                coils_we           = 1'b1;
                            end
                        end
                        FC_WRITE_REG: begin
                            if ((r_req.start_hi != 8'd0) || (r_req.start_lo >= 8'(REG_COUNT))) begin
                                n_rsp.exception_code = EXC_ILLEGAL_ADDR;
                            end else begin
                                n_rsp.kind         = KIND_ECHO;
                                n_rsp.echo_address = {8'd0, r_req.start_lo};
                                n_rsp.echo_value   = {r_req.qty_hi, r_req.qty_lo};
                                hold_we            = 1'b1;
                            end
                        end
                        FC_WRITE_COILS: begin
                            if (bad_coil) begin
                                n_rsp.exception_code = EXC_ILLEGAL_ADDR;
                            end else begin
                                n_rsp.kind         = KIND_ECHO;
                                n_rsp.echo_address = {8'd0, r_req.start_lo};
                                n_rsp.echo_value   = {8'd0, r_req.qty_lo};
                                coils_we           = 1'b1;
                            end
                        end
                        FC_WRITE_REGS: begin
                            if (bad_reg) begin
                                n_rsp.exception_code = EXC_ILLEGAL_ADDR;
                                set_discard          = 1'b1;
                            end else if (r_req.qty_lo == 8'd0) begin
                                n_rsp.kind         = KIND_ECHO;
                                n_rsp.echo_address = {8'd0, r_req.start_lo};
                            end else begin
                                has_rsp   = 1'b0;
                                start_pay = 1'b1;
                            end
                        end
                        default: begin
                            n_rsp.exception_code = EXC_ILLEGAL_FUNC;
                        end
                    endcase
                end
            end
            ACT_PAYLOAD: begin
                if (!r_discard && (r_pay_left != 4'd0)) begin
                    pay_step  = 1'b1;
                    hold_we   = 1'b1;
                    hold_addr = r_pay_index;
                    hold_data = r_req.word;
                    if (r_pay_left == 4'd1) begin
                        has_rsp            = 1'b1;
                        n_rsp.kind         = KIND_ECHO;
                        n_rsp.func_echo    = FC_WRITE_REGS;
                        n_rsp.echo_address = r_pend_addr;
                        n_rsp.echo_value   = r_pend_value;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // next register word of a read
    always_comb begin
        word_rsp           = '0;
        word_rsp.kind      = KIND_WORD;
        word_rsp.func_echo = r_req.function_code;
        word_rsp.reg_word  = r_word_input ? r_input[r_word_ptr] : r_holding[r_word_ptr];
        word_rsp.last      = (r_word_left == 4'd1);
    end

    // config, coils and the response sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= OWN_ADDRESS_RST;
            r_discrete    <= DISCRETE_RST;
            r_coils       <= COIL_RST;
            r_pay_left    <= '0;
            r_pay_index   <= '0;
            r_pend_addr   <= '0;
            r_pend_value  <= '0;
            r_discard     <= 1'b0;
            r_word_left   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OWN_ADDRESS:     r_own_address <= i_cfg_data;
                    CFG_DISCRETE_INPUTS: r_discrete    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.commit) begin
                if (coils_we) begin
                    if (r_req.function_code == FC_WRITE_COIL) begin
                        r_coils[r_req.start_lo[2:0]] <= (r_req.qty_hi == COIL_ON);
                    end else begin
                        r_coils <= n_coils;
                    end
                end
                if (hdr_clear) begin
                    r_pay_left  <= start_pay ? r_req.qty_lo[3:0] : 4'd0;
                    r_pay_index <= start_pay ? sl_idx : '0;
                    r_discard   <= set_discard;
                end
                if (start_pay) begin
                    r_pend_addr  <= {8'd0, r_req.start_lo};
                    r_pend_value <= {8'd0, r_req.qty_lo};
                end
                if (pay_step) begin
                    r_pay_left  <= r_pay_left - 4'd1;
                    r_pay_index <= r_pay_index + 1'b1;
                end
                if (multi) begin
                    r_word_left <= r_req.qty_lo[3:0];
                end
            end else if (i_cmd.emit_word) begin
                r_word_left <= r_word_left - 4'd1;
            end

            if ((i_cmd.commit && has_rsp) || i_cmd.emit_word) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // register stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_holding[i] <= '0;
                r_input[i]   <= '0;
            end
        end else if (i_cmd.commit) begin
            if (hold_we) begin
                r_holding[hold_addr] <= hold_data;
            end
            if ((r_req.action == ACT_LOAD) && ({1'b0, r_req.load_index} < 4'(REG_COUNT))) begin
                r_input[r_req.load_index[REG_AW-1:0]] <= r_req.word;
            end
        end
    end

    // payload registers: item latch, word pointer, output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        if (i_cmd.commit && multi) begin
            r_word_ptr   <= sl_idx;
            r_word_input <= (r_req.function_code == FC_READ_INPUT);
        end else if (i_cmd.emit_word) begin
            r_word_ptr <= r_word_ptr + 1'b1;
        end
        if (i_cmd.commit && has_rsp) begin
            r_out <= n_rsp;
        end else if (i_cmd.emit_word) begin
            r_out <= word_rsp;
        end
    end

    assign o_status.has_rsp   = has_rsp;
    assign o_status.multi     = multi;
    assign o_status.out_free  = out_free;
    assign o_status.word_last = (r_word_left == 4'd1);
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

endmodule

// File: rtl/core/modbus_slave_request_handler.sv
// Modbus slave request handler: top level, controller plus datapath.
// Depends on msrh_pkg, msrh_ctrl and msrh_dp.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall, i_in_data): one word per request
//    header, register payload word or input register load.
//  - Output channel (o_out_valid / i_out_stall, o_out_data): response words.
//    A register read gives a header word then one word per register, last
//    marked on the final one; writes give one echo, errors one exception.
//  - Config channel (i_cfg_valid / o_cfg_ready): own slave address (index 0)
//    and the discrete input byte (index 1). Always ready; write only while idle.
// Timing:
//  - An item is latched in ST_IDLE and executed in ST_EXEC; a register read
//    holds the input through ST_WORDS as well, one word a cycle out of the
//    single output register while the receiver does not stall.
//  - A finished word sits in the output register while the next item is
//    taken. If the receiver stalls, an item with a response waits in place
//    with its state updates held back until the output register has room.
// Reset (synchronous, active low): address 1, discrete inputs 0x09, coils
// 0x05, both register stores zero, no write pending, output empty.
module modbus_slave_request_handler
    import msrh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_req       i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_rsp       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // config writes are direct register loads
    assign o_cfg_ready = 1'b1;

    msrh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    msrh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
